>>> rtl/dtq_pkg.sv
`timescale 1ns / 1ps

package dtq_pkg;

    localparam int unsigned CMD_W = 2;
    localparam int unsigned ID_W  = 3;
    localparam int unsigned IVL_W = 31;

    localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_START = 2'd1;
    localparam logic [CMD_W-1:0] CMD_STOP  = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_DECIDE
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic ld_start;
        logic ld_stop;
        logic ld_tick;
        logic scan_clr;
        logic scan_en;
        logic commit;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic scan_last;
        logic best_vld;
        logic out_free;
    } t_dp_sts;

endpackage

>>> rtl/deadline_timer_queue_core.sv
`timescale 1ns / 1ps

// Bank of NUM_TIMERS one-shot timers on a TIME_WIDTH-bit millisecond clock. Start arms a
// timer at now plus interval, stop disarms it, tick advances time by one and then reports
// every armed timer whose deadline is strictly past, earliest deadline first (ties to the
// lower id), each as its own beat; the final beat of a tick has last set, and a tick with
// nothing due gives one beat with expired low. Start, stop and unused commands give no
// beat. A tick that expires k timers keeps the input stalled for k + 1 scan passes: the
// deadline memory has one read port, so each pass that finds the next timer visits the
// slots one per cycle, and a final pass finds none. A pass is held longer only while the
// previous output beat is not taken.
module deadline_timer_queue_core
    import dtq_pkg::*;
#(
    parameter int unsigned NUM_TIMERS = 8,
    parameter int unsigned TIME_WIDTH = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [CMD_W-1:0] i_command,
    input  logic [ID_W-1:0]  i_timer_id,
    input  logic [IVL_W-1:0] i_interval,
    output logic             o_valid,
    input  logic             i_ready,
    output logic             o_expired,
    output logic [ID_W-1:0]  o_expired_id,
    output logic             o_last
);

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    dtq_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .i_command (i_command),
        .o_ready   (o_ready),
        .i_sts     (dp_sts),
        .o_cmd     (dp_cmd)
    );

    dtq_dp #(
        .NUM_TIMERS (NUM_TIMERS),
        .TIME_WIDTH (TIME_WIDTH)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_timer_id   (i_timer_id),
        .i_interval   (i_interval),
        .i_ready      (i_ready),
        .i_cmd        (dp_cmd),
        .o_sts        (dp_sts),
        .o_valid      (o_valid),
        .o_expired    (o_expired),
        .o_expired_id (o_expired_id),
        .o_last       (o_last)
    );

endmodule

>>> rtl/dtq_ctrl.sv
`timescale 1ns / 1ps

module dtq_ctrl
    import dtq_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic [CMD_W-1:0] i_command,
    output logic             o_ready,
    input  t_dp_sts          i_sts,
    output t_dp_cmd          o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    unique case (i_command)
                        CMD_TICK: begin
                            o_cmd.ld_tick  = 1'b1;
                            o_cmd.scan_clr = 1'b1;
                            n_state        = S_SCAN;
                        end
                        CMD_START: o_cmd.ld_start = 1'b1;
                        CMD_STOP:  o_cmd.ld_stop  = 1'b1;
                        default: ;
                    endcase
                end
            end
            S_SCAN: begin
                o_cmd.scan_en = 1'b1;
                if (i_sts.scan_last) begin
                    n_state = S_DRAIN;
                end
            end
            // last slot's read data is compared here
            S_DRAIN: begin
                n_state = S_DECIDE;
            end
            S_DECIDE: begin
                if (i_sts.out_free) begin
                    o_cmd.commit = 1'b1;
                    if (i_sts.best_vld) begin
                        o_cmd.scan_clr = 1'b1;
                        n_state        = S_SCAN;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

>>> rtl/dtq_dp.sv
`timescale 1ns / 1ps

module dtq_dp
    import dtq_pkg::*;
#(
    parameter int unsigned NUM_TIMERS = 8,
    parameter int unsigned TIME_WIDTH = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [ID_W-1:0]  i_timer_id,
    input  logic [IVL_W-1:0] i_interval,
    input  logic             i_ready,
    input  t_dp_cmd          i_cmd,
    output t_dp_sts          o_sts,
    output logic             o_valid,
    output logic             o_expired,
    output logic [ID_W-1:0]  o_expired_id,
    output logic             o_last
);

    localparam int unsigned IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_TIMERS - 1);

    logic [TIME_WIDTH-1:0] r_mem [NUM_TIMERS];
    logic [TIME_WIDTH-1:0] r_time;
    logic [NUM_TIMERS-1:0] r_armed;
    logic [IDX_W-1:0]      r_idx;
    logic [TIME_WIDTH-1:0] r_rd_data;
    logic                  r_cmp_vld;
    logic [IDX_W-1:0]      r_cmp_idx;
    logic                  r_best_vld;
    logic [IDX_W-1:0]      r_best_idx;
    logic [TIME_WIDTH-1:0] r_best_dl;
    logic                  r_pend_vld;
    logic [IDX_W-1:0]      r_pend_idx;
    logic                  r_out_valid;
    logic                  r_out_expired;
    logic [ID_W-1:0]       r_out_id;
    logic                  r_out_last;

    logic                  id_ok;
    logic [IDX_W-1:0]      wr_idx;
    logic [TIME_WIDTH-1:0] new_dl;
    logic                  due;
    logic                  better;
    logic                  out_free;
    logic                  push;

    assign id_ok  = 32'(i_timer_id) < NUM_TIMERS;
    assign wr_idx = IDX_W'(i_timer_id);
    assign new_dl = r_time + TIME_WIDTH'(i_interval);

    assign due    = r_armed[r_cmp_idx] && (r_time > r_rd_data);
    assign better = !r_best_vld || (r_rd_data < r_best_dl);

    assign out_free = !r_out_valid || i_ready;
    // a found timer with nothing pending only parks itself
    assign push     = i_cmd.commit && (r_pend_vld || !r_best_vld);

    assign o_sts.scan_last = (r_idx == LAST_IDX);
    assign o_sts.best_vld  = r_best_vld;
    assign o_sts.out_free  = out_free;

    // deadline store, one write and one read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_start && id_ok) begin
            r_mem[wr_idx] <= new_dl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_en) begin
            r_rd_data <= r_mem[r_idx];
        end
        r_cmp_idx <= r_idx;
        if (i_cmd.commit) begin
            r_pend_idx <= r_best_idx;
        end
        if (r_cmp_vld && due && better) begin
            r_best_idx <= r_cmp_idx;
            r_best_dl  <= r_rd_data;
        end
        if (push) begin
            r_out_expired <= r_pend_vld;
            r_out_id      <= r_pend_vld ? ID_W'(r_pend_idx) : '0;
            r_out_last    <= !r_best_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time      <= '0;
            r_armed     <= '0;
            r_idx       <= '0;
            r_cmp_vld   <= 1'b0;
            r_best_vld  <= 1'b0;
            r_pend_vld  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.ld_tick) begin
                r_time <= r_time + 1'b1;
            end
            if (i_cmd.ld_start && id_ok) begin
                r_armed[wr_idx] <= 1'b1;
            end
            if (i_cmd.ld_stop && id_ok) begin
                r_armed[wr_idx] <= 1'b0;
            end
            if (i_cmd.commit && r_best_vld) begin
                r_armed[r_best_idx] <= 1'b0;
            end

            r_cmp_vld <= i_cmd.scan_en;
            if (i_cmd.scan_clr) begin
                r_idx <= '0;
            end else if (i_cmd.scan_en) begin
                r_idx <= (r_idx == LAST_IDX) ? '0 : r_idx + 1'b1;
            end

            if (i_cmd.scan_clr) begin
                r_best_vld <= 1'b0;
            end else if (r_cmp_vld && due) begin
                r_best_vld <= 1'b1;
            end

            if (i_cmd.commit) begin
                r_pend_vld <= r_best_vld;
            end

            if (push) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid      = r_out_valid;
    assign o_expired    = r_out_expired;
    assign o_expired_id = r_out_id;
    assign o_last       = r_out_last;

endmodule

>>> rtl/dtq_checker.sv
`timescale 1ns / 1ps

module dtq_checker
    import dtq_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_valid,
    input logic             o_ready,
    input logic [CMD_W-1:0] i_command,
    input logic             o_valid,
    input logic             i_ready,
    input logic             o_expired,
    input logic [ID_W-1:0]  o_expired_id,
    input logic             o_last
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable({o_expired, o_expired_id, o_last}))
        else $error("result beat changed while stalled");

    // empty beat only closes a tick
    a_empty_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_expired |-> o_last && (o_expired_id == '0))
        else $error("empty beat without last or with nonzero id");

    // tick busies the block while it scans
    a_tick_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready && (i_command == CMD_TICK) |=> !o_ready)
        else $error("input ready right after a tick");

    // start and stop never raise a result
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready && (i_command != CMD_TICK) && !o_valid |=> !o_valid)
        else $error("result beat after a start or stop");

endmodule

bind deadline_timer_queue_core dtq_checker u_dtq_checker (.*);
